// ----- sv/bqs_pkg.sv -----
`timescale 1ns / 1ps
package bqs_pkg;

  // request kinds on the input
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // divide by ten: x * RECIP10 >> RECIP_SHIFT, exact for x below 262149
  localparam int unsigned RECIP10     = 52429;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned CMD_BIN_W   = 12;
  localparam int unsigned NUM_STATS   = 5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] ref_mag;
    logic signed [15:0] iso_mag;
    logic [7:0]         quality_flag;
    logic [10:0]        query_bin;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         bin_count;
    logic signed [15:0] bin_min;
    logic signed [15:0] bin_p10;
    logic signed [15:0] bin_median;
    logic signed [15:0] bin_p90;
    logic signed [15:0] bin_max;
    logic signed [15:0] all_min_ref;
    logic signed [15:0] all_max_ref;
    logic signed [15:0] all_min_iso;
    logic signed [15:0] all_max_iso;
    logic [15:0]        full_drops;
    logic [15:0]        range_drops;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ADD,
    CMD_RDROP,
    CMD_QUERY,
    CMD_QEMPTY,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [CMD_BIN_W-1:0]  bin;
    logic signed [15:0]    ref_mag;
    logic signed [15:0]    iso_mag;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_DECIDE,
    BK_SHRD,
    BK_SHCMP,
    BK_QIDX,
    BK_QRD,
    BK_QCAP,
    BK_OUT
  } bk_state_t;

endpackage

// ----- sv/bqs_front.sv -----
`timescale 1ns / 1ps
module bqs_front #(
  parameter int unsigned NUM_BINS = 2048
) (
  input  bqs_pkg::in_item_t item,
  output bqs_pkg::cmd_t     cmd
);

  logic [16:0] mag_abs;
  logic [33:0] prod;
  logic [13:0] quot;
  logic        out_of_range;

  assign mag_abs = item.ref_mag[15] ? 17'(-{item.ref_mag[15], item.ref_mag})
                                    : {1'b0, item.ref_mag};
  assign prod = 34'(mag_abs) * 34'(bqs_pkg::RECIP10);
  assign quot = prod[bqs_pkg::RECIP_SHIFT +: 14];
  // negative bins other than zero, or past the last bin
  assign out_of_range = (item.ref_mag[15] && quot != 14'd0) || (32'(quot) >= NUM_BINS);

  always_comb begin
    cmd.bin     = quot[bqs_pkg::CMD_BIN_W-1:0];
    cmd.ref_mag = item.ref_mag;
    cmd.iso_mag = item.iso_mag;
    cmd.op      = bqs_pkg::CMD_NOP;
    case (item.req_type)
      bqs_pkg::REQ_ADD: begin
        if (item.quality_flag == 8'd1) begin
          cmd.op = out_of_range ? bqs_pkg::CMD_RDROP : bqs_pkg::CMD_ADD;
        end
      end
      bqs_pkg::REQ_QUERY: begin
        cmd.bin = bqs_pkg::CMD_BIN_W'(item.query_bin);
        cmd.op  = (32'(item.query_bin) < NUM_BINS) ? bqs_pkg::CMD_QUERY
                                                    : bqs_pkg::CMD_QEMPTY;
      end
      bqs_pkg::REQ_CLEAR: cmd.op = bqs_pkg::CMD_CLEAR;
      default: cmd.op = bqs_pkg::CMD_NOP;
    endcase
  end

endmodule

// ----- sv/bqs_queue.sv -----
`timescale 1ns / 1ps
module bqs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bqs_pkg::cmd_t push_cmd,
  input  logic          pop,
  output bqs_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  bqs_pkg::cmd_t                 slots [bqs_pkg::QUEUE_DEPTH];
  logic [bqs_pkg::QPTR_W-1:0]    wr_ptr;
  logic [bqs_pkg::QPTR_W-1:0]    rd_ptr;
  logic [bqs_pkg::QPTR_W:0]      fill;

  assign full  = (fill == (bqs_pkg::QPTR_W+1)'(bqs_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- sv/bqs_back.sv -----
`timescale 1ns / 1ps
module bqs_back #(
  parameter int unsigned NUM_BINS  = 2048,
  parameter int unsigned BIN_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bqs_pkg::cmd_t      head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output bqs_pkg::out_item_t out_data
);

  localparam int unsigned BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned FILL_W = $clog2(BIN_DEPTH + 1);
  localparam int unsigned ENTRIES = NUM_BINS * BIN_DEPTH;
  localparam int unsigned ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [FILL_W-1:0]        fill_mem [NUM_BINS];
  logic signed [15:0]       val_mem  [ENTRIES];

  bqs_pkg::bk_state_t state, state_next;
  bqs_pkg::cmd_t      cmd;
  logic [ADDR_W-1:0]  base;
  logic [FILL_W-1:0]  j;
  logic [FILL_W-1:0]  cnt;
  logic [FILL_W-1:0]  idx;
  logic [FILL_W-1:0]  idx_next;
  logic [2:0]         k;
  logic signed [15:0] stat [bqs_pkg::NUM_STATS];
  logic signed [15:0] low_ref, high_ref, low_iso, high_iso;
  logic [15:0]        full_drops, range_drops;
  logic [BIN_W-1:0]   sweep_cnt;
  logic               clr_reply;

  logic [FILL_W-1:0]  fill_q;
  logic signed [15:0] val_q;
  logic               fill_we;
  logic [BIN_W-1:0]   fill_waddr;
  logic [FILL_W-1:0]  fill_wdata;
  logic               val_we;
  logic [ADDR_W-1:0]  val_waddr;
  logic signed [15:0] val_wdata;
  logic [ADDR_W-1:0]  val_raddr;
  logic [31:0]        num;
  logic [31:0]        prod;
  logic               out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_q <= fill_mem[head.bin[BIN_W-1:0]];
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_q <= val_mem[val_raddr];
  end

  // quantile index for the current pick
  assign num  = (k == 3'd3) ? 32'(cnt) * 32'd9 : 32'(cnt);
  assign prod = 32'(num[15:0]) * 32'(bqs_pkg::RECIP10);
  always_comb begin
    case (k)
      3'd0:    idx_next = '0;
      3'd1:    idx_next = FILL_W'(prod >> bqs_pkg::RECIP_SHIFT);
      3'd2:    idx_next = cnt >> 1;
      3'd3:    idx_next = FILL_W'(prod >> bqs_pkg::RECIP_SHIFT);
      default: idx_next = cnt - 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = cmd.bin[BIN_W-1:0];
    fill_wdata = fill_q + 1'b1;
    val_we     = 1'b0;
    val_waddr  = base + ADDR_W'(j);
    val_wdata  = cmd.iso_mag;
    val_raddr  = base + ADDR_W'(j) - 1'b1;
    case (state)
      bqs_pkg::BK_SWEEP: begin
        fill_we    = 1'b1;
        fill_waddr = sweep_cnt;
        fill_wdata = '0;
        if (32'(sweep_cnt) == NUM_BINS - 1) begin
          state_next = clr_reply ? bqs_pkg::BK_OUT : bqs_pkg::BK_IDLE;
        end
      end
      bqs_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.op)
            bqs_pkg::CMD_ADD, bqs_pkg::CMD_QUERY: state_next = bqs_pkg::BK_DECIDE;
            bqs_pkg::CMD_CLEAR: state_next = bqs_pkg::BK_SWEEP;
            default: state_next = bqs_pkg::BK_OUT;
          endcase
        end
      end
      bqs_pkg::BK_DECIDE: begin
        if (cmd.op == bqs_pkg::CMD_ADD) begin
          if (fill_q >= FILL_W'(BIN_DEPTH)) begin
            state_next = bqs_pkg::BK_OUT;
          end else begin
            fill_we    = 1'b1;
            state_next = bqs_pkg::BK_SHRD;
          end
        end else begin
          state_next = (fill_q == '0) ? bqs_pkg::BK_OUT : bqs_pkg::BK_QIDX;
        end
      end
      bqs_pkg::BK_SHRD: begin
        if (j == '0) begin
          val_we     = 1'b1;
          state_next = bqs_pkg::BK_OUT;
        end else begin
          state_next = bqs_pkg::BK_SHCMP;
        end
      end
      bqs_pkg::BK_SHCMP: begin
        val_we = 1'b1;
        if (val_q > cmd.iso_mag) begin
          val_wdata  = val_q;
          state_next = bqs_pkg::BK_SHRD;
        end else begin
          state_next = bqs_pkg::BK_OUT;
        end
      end
      bqs_pkg::BK_QIDX: state_next = bqs_pkg::BK_QRD;
      bqs_pkg::BK_QRD: begin
        val_raddr  = base + ADDR_W'(idx);
        state_next = bqs_pkg::BK_QCAP;
      end
      bqs_pkg::BK_QCAP: begin
        state_next = (k == 3'(bqs_pkg::NUM_STATS - 1)) ? bqs_pkg::BK_OUT
                                                       : bqs_pkg::BK_QIDX;
      end
      bqs_pkg::BK_OUT: begin
        if (out_free) state_next = bqs_pkg::BK_IDLE;
      end
      default: state_next = bqs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bqs_pkg::BK_SWEEP;
      sweep_cnt   <= '0;
      clr_reply   <= 1'b0;
      out_valid   <= 1'b0;
      low_ref     <= 16'sh7FFF;
      high_ref    <= -16'sh8000;
      low_iso     <= 16'sh7FFF;
      high_iso    <= -16'sh8000;
      full_drops  <= '0;
      range_drops <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != bqs_pkg::BK_OUT) out_valid <= 1'b0;
      case (state)
        bqs_pkg::BK_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (32'(sweep_cnt) == NUM_BINS - 1) clr_reply <= 1'b0;
        end
        bqs_pkg::BK_IDLE: begin
          if (!q_empty) begin
            cmd  <= head;
            base <= ADDR_W'(head.bin[BIN_W-1:0]) * ADDR_W'(BIN_DEPTH);
            cnt  <= '0;
            for (int s = 0; s < bqs_pkg::NUM_STATS; s++) stat[s] <= '0;
            if (head.op == bqs_pkg::CMD_ADD || head.op == bqs_pkg::CMD_RDROP) begin
              if (head.ref_mag < low_ref)  low_ref  <= head.ref_mag;
              if (head.ref_mag > high_ref) high_ref <= head.ref_mag;
              if (head.iso_mag < low_iso)  low_iso  <= head.iso_mag;
              if (head.iso_mag > high_iso) high_iso <= head.iso_mag;
            end
            if (head.op == bqs_pkg::CMD_RDROP && range_drops != 16'hFFFF) begin
              range_drops <= range_drops + 1'b1;
            end
            if (head.op == bqs_pkg::CMD_CLEAR) begin
              low_ref     <= 16'sh7FFF;
              high_ref    <= -16'sh8000;
              low_iso     <= 16'sh7FFF;
              high_iso    <= -16'sh8000;
              full_drops  <= '0;
              range_drops <= '0;
              sweep_cnt   <= '0;
              clr_reply   <= 1'b1;
            end
          end
        end
        bqs_pkg::BK_DECIDE: begin
          if (cmd.op == bqs_pkg::CMD_ADD) begin
            if (fill_q >= FILL_W'(BIN_DEPTH)) begin
              if (full_drops != 16'hFFFF) full_drops <= full_drops + 1'b1;
            end else begin
              j <= fill_q;
            end
          end else begin
            cnt <= fill_q;
            k   <= '0;
          end
        end
        bqs_pkg::BK_SHCMP: begin
          if (val_q > cmd.iso_mag) j <= j - 1'b1;
        end
        bqs_pkg::BK_QIDX: idx <= idx_next;
        bqs_pkg::BK_QCAP: begin
          stat[k] <= val_q;
          k       <= k + 1'b1;
        end
        bqs_pkg::BK_OUT: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.bin_count    <= 6'(cnt);
            out_data.bin_min      <= stat[0];
            out_data.bin_p10      <= stat[1];
            out_data.bin_median   <= stat[2];
            out_data.bin_p90      <= stat[3];
            out_data.bin_max      <= stat[4];
            out_data.all_min_ref  <= low_ref;
            out_data.all_max_ref  <= high_ref;
            out_data.all_min_iso  <= low_iso;
            out_data.all_max_iso  <= high_iso;
            out_data.full_drops   <= full_drops;
            out_data.range_drops  <= range_drops;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/binned_quantile_stats.sv -----
`timescale 1ns / 1ps
// channel  | signals                       | payload
// ---------+-------------------------------+-----------------------------
// in       | in_valid, in_ready, in_data   | bqs_pkg::in_item_t request
// out      | out_valid, out_ready, out_data| bqs_pkg::out_item_t result
//
// one result item for every request item, in order
// add: an insertion walk through the value memory (one read and one write
//   port) shifts every larger value of the bin up by one slot
// query: five registered memory reads, one per statistic
// reset and clear both run a clearing pass over every bin of the fill
//   memory; requests queue up (four deep) but are not executed meanwhile
// the front stalls only when the queue is full, the back only on out_ready
module binned_quantile_stats #(
  parameter int unsigned NUM_BINS  = 2048,
  parameter int unsigned BIN_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bqs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bqs_pkg::out_item_t out_data
);

  bqs_pkg::cmd_t front_cmd;
  bqs_pkg::cmd_t head;
  logic          q_full;
  logic          q_empty;
  logic          pop;

  // classify the item and work out its bin
  bqs_front #(.NUM_BINS(NUM_BINS)) u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  assign in_ready = !q_full;

  // short queue between classification and execution
  bqs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && in_ready),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // bin memories, sorted insertion, quantile reads and result register
  bqs_back #(.NUM_BINS(NUM_BINS), .BIN_DEPTH(BIN_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
